>>> hw/rtl/sfr_pkg.sv
// Shared constants, register codes and cell control types for the stream
// find-and-replace block. No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

  localparam int MAX_PATTERN     = 8;
  localparam int MAX_REPLACEMENT = 8;
  localparam int LIMIT_WIDTH     = 16;

  // Longest run of results that one item can cause.
  localparam int MAX_BURST = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;

  localparam int PAT_W   = MAX_PATTERN * 8;
  localparam int REPL_W  = MAX_REPLACEMENT * 8;
  localparam int PLEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int RLEN_W  = $clog2(MAX_REPLACEMENT + 1);
  localparam int BURST_W = $clog2(MAX_BURST + 1);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN      = 3'd0,
    REG_PATTERN_LEN  = 3'd1,
    REG_REPLACE      = 3'd2,
    REG_REPLACE_LEN  = 3'd3,
    REG_OUTPUT_LIMIT = 3'd4
  } sfr_reg_e;

  localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = LIMIT_WIDTH'(255);

  typedef struct packed {
    logic load;   // take a new item into the window
    logic shift;  // age out the oldest byte
  } sfr_win_ctl_t;

  typedef struct packed {
    logic load;   // take a new burst
    logic shift;  // advance the burst by one byte
  } sfr_out_ctl_t;

endpackage

>>> hw/rtl/sfr_win_cell.sv
// One byte of the match window: holds a byte, compares it against its
// pattern byte and hands its new byte to its left neighbor. Uses sfr_pkg.
`timescale 1ns / 1ps

module sfr_win_cell (
  input  logic                clk_i,
  input  sfr_pkg::sfr_win_ctl_t ctl_i,
  input  logic                insert_i,
  input  logic [7:0]          data_byte_i,
  input  logic [7:0]          right_i,
  input  logic [7:0]          pat_byte_i,
  input  logic                active_i,
  output logic [7:0]          new_byte_o,
  output logic                match_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  // Window contents once the incoming byte is in place.
  assign new_byte_o = insert_i ? data_byte_i : byte_q;
  assign match_o    = !active_i || (new_byte_o == pat_byte_i);

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.load) begin
      byte_d = ctl_i.shift ? right_i : new_byte_o;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

endmodule

>>> hw/rtl/sfr_out_cell.sv
// One byte of the output burst chain: loads a burst byte or takes its
// right neighbor's byte as the chain advances. Uses sfr_pkg.
`timescale 1ns / 1ps

module sfr_out_cell (
  input  logic                  clk_i,
  input  sfr_pkg::sfr_out_ctl_t ctl_i,
  input  logic [7:0]            load_byte_i,
  input  logic [7:0]            right_i,
  output logic [7:0]            byte_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctl_i.load) begin
      byte_d = load_byte_i;
    end else if (ctl_i.shift) begin
      byte_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

>>> hw/rtl/stream_find_replace.sv
// Top level of the stream find-and-replace block: control, limit count,
// window cell row and output burst chain. Uses sfr_pkg, sfr_win_cell and
// sfr_out_cell.
`timescale 1ns / 1ps

// Replaces each leftmost, non-overlapping occurrence of a pattern of up to
// eight bytes in a byte stream with a replacement of zero to eight bytes.
// Bytes wait in a row of window cells, one cell per pattern byte, until
// they either complete a match or age out. Every input item loads its
// results (zero to eight bytes, or a bare end marker) into a chain of
// output cells that shifts one result per cycle toward the output port
// while out_stall_i is low. Items that cause at most one result enter one
// per cycle while the output does not stall; an item that causes more
// holds the input until the chain has delivered its results, and the next
// item enters in the cycle the last result of the previous one leaves.
// Configuration writes are taken at any time (ready stays high) but are
// meant for idle periods; writing the pattern length discards the window.

module stream_find_replace (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [7:0]                     data_byte_i,
  input  logic                           end_of_input_i,
  // result items
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [7:0]                     out_byte_o,
  output logic                           byte_present_o,
  output logic                           string_done_o,
  output logic                           run_last_o,
  output logic                           was_truncated_o
);

  localparam int MP = sfr_pkg::MAX_PATTERN;
  localparam int MR = sfr_pkg::MAX_REPLACEMENT;
  localparam int MB = sfr_pkg::MAX_BURST;
  localparam int PW = sfr_pkg::PLEN_W;
  localparam int RW = sfr_pkg::RLEN_W;
  localparam int BW = sfr_pkg::BURST_W;
  localparam int LW = sfr_pkg::LIMIT_WIDTH;

  // Configuration registers.
  logic [sfr_pkg::PAT_W-1:0]  pat_q;
  logic [PW-1:0]              plen_q;
  logic [sfr_pkg::REPL_W-1:0] repl_q;
  logic [RW-1:0]              rlen_q;
  logic [LW-1:0]              limit_q;

  // Stream state.
  logic [PW-1:0] fill_q, fill_d;
  logic [LW-1:0] count_q, count_d;
  logic          drop_q, drop_d;

  // Output burst state.
  logic [BW-1:0] rem_q, rem_d;
  logic          end_q, end_d;
  logic          trunc_q, trunc_d;
  logic          bare_q, bare_d;

  logic in_take;
  logic out_take;
  logic cfg_take;

  assign cfg_ready_o = 1'b1;
  assign cfg_take    = cfg_valid_i && cfg_ready_o;

  // Accept a new item when the burst chain is empty or its last result
  // leaves in this cycle.
  assign out_valid_o = (rem_q != '0);
  assign out_take    = out_valid_o && !out_stall_i;
  assign in_stall_o  = (rem_q != '0) && !((rem_q == BW'(1)) && out_take);
  assign in_take     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------------
  // Window cell row
  // ---------------------------------------------------------------------
  logic          pass_mode;
  logic [PW-1:0] fill_eff;
  logic [PW-1:0] fill_inc;
  logic          win_full;
  logic          hit;
  logic [MP-1:0] match;
  logic [7:0]    win_new [MP];

  sfr_pkg::sfr_win_ctl_t win_ctl;

  assign pass_mode = (plen_q == '0);
  // Restart the window if it somehow holds a whole pattern already.
  assign fill_eff  = (fill_q >= plen_q) ? '0 : fill_q;
  assign fill_inc  = fill_eff + PW'(1);
  assign win_full  = (fill_inc == plen_q);
  assign hit       = win_full && (&match);

  assign win_ctl.load  = in_take && !pass_mode;
  assign win_ctl.shift = win_full && !hit;

  for (genvar i = 0; i < MP; i++) begin : g_win
    logic [7:0] right;
    if (i < MP - 1) begin : g_mid
      assign right = win_new[i+1];
    end else begin : g_end
      assign right = win_new[i];
    end

    sfr_win_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (win_ctl),
      .insert_i    (fill_eff == PW'(i)),
      .data_byte_i (data_byte_i),
      .right_i     (right),
      .pat_byte_i  (pat_q[i*8 +: 8]),
      .active_i    (PW'(i) < plen_q),
      .new_byte_o  (win_new[i]),
      .match_o     (match[i])
    );
  end

  // ---------------------------------------------------------------------
  // Burst size and output limit
  // ---------------------------------------------------------------------
  logic [BW-1:0] burst_n;
  logic [LW-1:0] avail;
  logic          short;
  logic [BW-1:0] emit_n;

  always_comb begin
    if (pass_mode) begin
      burst_n = BW'(1);
    end else if (hit) begin
      burst_n = BW'(rlen_q);
    end else if (win_full) begin
      // Oldest byte ages out; at end of string flush the rest too.
      burst_n = end_of_input_i ? BW'(plen_q) : BW'(1);
    end else begin
      burst_n = end_of_input_i ? BW'(fill_inc) : '0;
    end
  end

  assign avail  = (limit_q > count_q) ? (limit_q - count_q) : '0;
  assign short  = (avail < LW'(burst_n));
  assign emit_n = short ? avail[BW-1:0] : burst_n;

  always_comb begin
    fill_d  = fill_q;
    count_d = count_q;
    drop_d  = drop_q;
    if (in_take) begin
      count_d = count_q + LW'(emit_n);
      drop_d  = drop_q || short;
      if (!pass_mode) begin
        if (hit) begin
          fill_d = '0;
        end else if (win_full) begin
          fill_d = plen_q - PW'(1);
        end else begin
          fill_d = fill_inc;
        end
      end
      // End of string: start the next one clean.
      if (end_of_input_i) begin
        fill_d  = '0;
        count_d = '0;
        drop_d  = 1'b0;
      end
    end
    if (cfg_take && (cfg_index_i == sfr_pkg::REG_PATTERN_LEN)) begin
      fill_d = '0;
    end
  end

  // ---------------------------------------------------------------------
  // Output burst chain
  // ---------------------------------------------------------------------
  sfr_pkg::sfr_out_ctl_t out_ctl;
  logic [7:0] out_cell [MB];

  assign out_ctl.load  = in_take;
  assign out_ctl.shift = out_take;

  for (genvar j = 0; j < MB; j++) begin : g_out
    logic [7:0] win_b;
    logic [7:0] repl_b;
    logic [7:0] load_b;
    logic [7:0] right;

    if (j < MP) begin : g_w
      assign win_b = win_new[j];
    end else begin : g_wz
      assign win_b = 8'h00;
    end
    if (j < MR) begin : g_r
      assign repl_b = repl_q[j*8 +: 8];
    end else begin : g_rz
      assign repl_b = 8'h00;
    end
    if (j < MB - 1) begin : g_mid
      assign right = out_cell[j+1];
    end else begin : g_end
      assign right = 8'h00;
    end

    always_comb begin
      if (pass_mode) begin
        load_b = data_byte_i;
      end else if (hit) begin
        load_b = repl_b;
      end else begin
        load_b = win_b;
      end
    end

    sfr_out_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (out_ctl),
      .load_byte_i (load_b),
      .right_i     (right),
      .byte_o      (out_cell[j])
    );
  end

  always_comb begin
    rem_d   = rem_q;
    end_d   = end_q;
    trunc_d = trunc_q;
    bare_d  = bare_q;
    if (in_take) begin
      // Nothing to emit at end of string: send one bare end marker.
      rem_d   = (emit_n == '0) ? (end_of_input_i ? BW'(1) : '0) : emit_n;
      end_d   = end_of_input_i;
      trunc_d = drop_q || short;
      bare_d  = (emit_n == '0);
    end else if (out_take) begin
      rem_d = rem_q - BW'(1);
    end
  end

  assign out_byte_o      = bare_q ? 8'h00 : out_cell[0];
  assign byte_present_o  = !bare_q;
  assign run_last_o      = (rem_q == BW'(1));
  assign string_done_o   = end_q && run_last_o;
  assign was_truncated_o = end_q && run_last_o && trunc_q;

  // ---------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q   <= '0;
      plen_q  <= '0;
      repl_q  <= '0;
      rlen_q  <= '0;
      limit_q <= sfr_pkg::LIMIT_RESET;
    end else if (cfg_take) begin
      case (cfg_index_i)
        sfr_pkg::REG_PATTERN: begin
          pat_q <= cfg_data_i[sfr_pkg::PAT_W-1:0];
        end
        sfr_pkg::REG_PATTERN_LEN: begin
          // Saturate 4-bit lengths above the window size; upper data bits are ignored.
          plen_q <= (cfg_data_i[3:0] > 4'(MP)) ? PW'(MP) : PW'(cfg_data_i[3:0]);
        end
        sfr_pkg::REG_REPLACE: begin
          repl_q <= cfg_data_i[sfr_pkg::REPL_W-1:0];
        end
        sfr_pkg::REG_REPLACE_LEN: begin
          rlen_q <= (cfg_data_i[3:0] > 4'(MR)) ? RW'(MR) : RW'(cfg_data_i[3:0]);
        end
        sfr_pkg::REG_OUTPUT_LIMIT: begin
          limit_q <= LW'(cfg_data_i[15:0]);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      count_q <= '0;
      drop_q  <= 1'b0;
      rem_q   <= '0;
      end_q   <= 1'b0;
      trunc_q <= 1'b0;
      bare_q  <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      rem_q   <= rem_d;
      end_q   <= end_d;
      trunc_q <= trunc_d;
      bare_q  <= bare_d;
    end
  end

endmodule
